// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/ggc_pkg.sv =====
// shared types and constants of the greedy graph colorer
package ggc_pkg;

    // graph size and field widths
    localparam int MAX_VERTICES = 32;
    localparam int VIDX_W       = 5;
    localparam int ROW_W        = 32;
    localparam int COLOR_W      = 5;
    localparam int COLOR_SET_W  = 2 ** COLOR_W;
    localparam int MAX_COLOR    = COLOR_SET_W - 1;
    localparam int VCNT_W       = 6;

    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(32);

    // input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic              command;
        logic [VIDX_W-1:0] row_index;
        logic [ROW_W-1:0]  row_flags;
    } in_item_t;

    typedef struct packed {
        logic [VIDX_W-1:0]  vertex;
        logic [COLOR_W-1:0] color;
        logic               last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_row;
        logic start;
        logic clear_cnt;
        logic color_step;
        logic emit_step;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_last;
        logic count_zero;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/core/ggc_ram.sv =====
// generic single write port ram with registered read
module ggc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ggc_datapath.sv =====
// adjacency store, color lanes, first-fit search and result register
module ggc_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [ggc_pkg::VCNT_W-1:0]   cfg_wr_data,
    input  ggc_pkg::in_item_t            s_data,
    input  ggc_pkg::ctrl_cmd_t           cmd,
    output ggc_pkg::dp_status_t          status,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ggc_pkg::out_item_t           m_data
);

    logic [ggc_pkg::VCNT_W-1:0]      vcnt_reg;
    logic [ggc_pkg::VCNT_W-1:0]      n_used;
    logic [ggc_pkg::VIDX_W-1:0]      last_idx;
    logic [ggc_pkg::VIDX_W-1:0]      cnt_reg;
    logic [ggc_pkg::VIDX_W-1:0]      rd_addr;
    logic [ggc_pkg::ROW_W-1:0]       row_data;
    logic [ggc_pkg::COLOR_W-1:0]     color_reg  [ggc_pkg::MAX_VERTICES];
    logic [ggc_pkg::COLOR_SET_W-1:0] forbid_reg [ggc_pkg::MAX_VERTICES];
    logic [ggc_pkg::COLOR_SET_W-1:0] used_colors;
    logic [ggc_pkg::COLOR_SET_W-1:0] new_color_bit;
    logic [ggc_pkg::COLOR_W-1:0]     new_color;
    logic                            m_valid_reg;
    ggc_pkg::out_item_t              out_reg;

    // vertex count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg <= ggc_pkg::VCNT_RESET;
        end else if (cfg_wr_en) begin
            vcnt_reg <= cfg_wr_data;
        end
    end

    // clamp to the store size, index of the final vertex
    assign n_used   = (vcnt_reg > ggc_pkg::VCNT_W'(ggc_pkg::MAX_VERTICES))
                    ? ggc_pkg::VCNT_W'(ggc_pkg::MAX_VERTICES) : vcnt_reg;
    assign last_idx = ggc_pkg::VIDX_W'(n_used - ggc_pkg::VCNT_W'(1));

    // vertex counter shared by coloring and emitting
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.clear_cnt) begin
            cnt_reg <= '0;
        end else if (cmd.color_step || cmd.emit_step) begin
            cnt_reg <= cnt_reg + ggc_pkg::VIDX_W'(1);
        end
    end

    // prefetch the next row while the current vertex is colored
    assign rd_addr = cmd.color_step ? cnt_reg + ggc_pkg::VIDX_W'(1) : cnt_reg;

    ggc_ram #(
        .WIDTH (ggc_pkg::ROW_W),
        .DEPTH (ggc_pkg::MAX_VERTICES)
    ) u_adj_ram (
        .aclk  (aclk),
        .we    (cmd.load_row),
        .waddr (s_data.row_index),
        .wdata (s_data.row_flags),
        .raddr (rd_addr),
        .rdata (row_data)
    );

    // colors held by earlier neighbors: own row backward, other rows via forbid mask
    always_comb begin
        used_colors = forbid_reg[cnt_reg];
        for (int j = 0; j < ggc_pkg::MAX_VERTICES; j++) begin
            if (row_data[j] && (ggc_pkg::VIDX_W'(j) < cnt_reg)) begin
                used_colors = used_colors
                            | (ggc_pkg::COLOR_SET_W'(1) << color_reg[j]);
            end
        end
    end

    // first free color, top color when all lower ones are taken
    always_comb begin
        new_color = ggc_pkg::COLOR_W'(ggc_pkg::MAX_COLOR);
        for (int b = ggc_pkg::MAX_COLOR - 1; b >= 0; b--) begin
            if (!used_colors[b]) begin
                new_color = ggc_pkg::COLOR_W'(b);
            end
        end
    end

    assign new_color_bit = ggc_pkg::COLOR_SET_W'(1) << new_color;

    // color lanes and forward forbid masks
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            for (int k = 0; k < ggc_pkg::MAX_VERTICES; k++) begin
                forbid_reg[k] <= '0;
            end
        end else if (cmd.color_step) begin
            color_reg[cnt_reg] <= new_color;
            for (int k = 0; k < ggc_pkg::MAX_VERTICES; k++) begin
                if (row_data[k] && (ggc_pkg::VIDX_W'(k) > cnt_reg)) begin
                    forbid_reg[k] <= forbid_reg[k] | new_color_bit;
                end
            end
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_step) begin
            out_reg.vertex <= cnt_reg;
            out_reg.color  <= color_reg[cnt_reg];
            out_reg.last   <= (cnt_reg == last_idx);
        end
    end

    assign status.cnt_last   = (cnt_reg == last_idx);
    assign status.count_zero = (vcnt_reg == '0);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== rtl/core/ggc_ctrl.sv =====
// controller state machine for load, coloring and result transfer
module ggc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  ggc_pkg::dp_status_t status,
    output ggc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_COLOR,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_command == ggc_pkg::CMD_LOAD) begin
                        cmd.load_row = 1'b1;
                    end else if (!status.count_zero) begin
                        cmd.start     = 1'b1;
                        cmd.clear_cnt = 1'b1;
                        state_next    = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_COLOR;
            end
            ST_COLOR: begin
                cmd.color_step = 1'b1;
                if (status.cnt_last) begin
                    cmd.clear_cnt = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_step = 1'b1;
                    if (status.cnt_last) begin
                        cmd.clear_cnt = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ===== rtl/core/greedy_graph_colorer_unit.sv =====
// top level of the greedy first-fit graph colorer
// A load transfer writes one adjacency row into the row RAM and leaves the block idle. A start
// transfer colors vertices 0 to n-1 in index order, n being vertex_count clamped to 32:
// the first row is read in the fetch state, then one vertex per cycle, since the row RAM serves
// one row per cycle and the next row is read while the current vertex is colored. The n
// results then leave through the output register at one per cycle while m_ready is high.
// A start holds off further input until its last result enters the output register; one with a
// vertex_count of zero gives no results. Rows must be loaded before a start reads them;
// vertex_count must be written only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module greedy_graph_colorer_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ggc_pkg::VCNT_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ggc_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ggc_pkg::out_item_t         m_data
);

    ggc_pkg::ctrl_cmd_t  cmd;
    ggc_pkg::dp_status_t status;

    ggc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_data.command),
        .status    (status),
        .cmd       (cmd)
    );

    ggc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // a result is loaded only into a free output register
    `ASSERT_PROP(a_emit_into_free, aclk, aresetn, cmd.emit_step |-> status.out_free)

    // coloring and result transfer never overlap
    `ASSERT_NEVER(a_color_emit_excl, aclk, aresetn, cmd.color_step && cmd.emit_step)

    // row writes and starts only come with an input transfer
    `ASSERT_PROP(a_cmd_on_xfer, aclk, aresetn, (cmd.load_row || cmd.start) |-> s_valid && s_ready)

    // a freshly loaded result is presented at the next edge
    `ASSERT_PROP(a_emit_shows_valid, aclk, aresetn, cmd.emit_step |=> m_valid)

endmodule

// ===== dv/ggc_checker.sv =====
// result checker for the greedy graph colorer: predicts colorings and compares transfers
`timescale 1ns / 100ps

module ggc_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ggc_pkg::VCNT_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  ggc_pkg::in_item_t          s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  ggc_pkg::out_item_t         m_data,
    output int                         errors,
    output int                         pending
);

    // shadow copy of the block state
    logic [ggc_pkg::ROW_W-1:0]   adj_rows [ggc_pkg::MAX_VERTICES];
    logic [ggc_pkg::COLOR_W-1:0] vtx_colors [ggc_pkg::MAX_VERTICES];
    logic [ggc_pkg::VCNT_W-1:0]  vertex_count = ggc_pkg::VCNT_RESET;

    // colorings still owed by the block, oldest first
    ggc_pkg::out_item_t color_queue [$];
    ggc_pkg::out_item_t want;
    int                 err_count = 0;

    // first-fit coloring of vertices 0 .. n-1, queues one result per vertex
    task automatic predict_coloring();
        int                              n;
        int                              c;
        logic [ggc_pkg::COLOR_SET_W-1:0] taken;
        ggc_pkg::out_item_t              res;
        n = (vertex_count > ggc_pkg::MAX_VERTICES)
          ? ggc_pkg::MAX_VERTICES : int'(vertex_count);
        for (int i = 0; i < n; i++) begin
            taken = '0;
            // j < i keeps self-loops out, either direction makes an edge
            for (int j = 0; j < i; j++) begin
                if (adj_rows[i][j] || adj_rows[j][i])
                    taken[vtx_colors[j]] = 1'b1;
            end
            c = 0;
            while (c < ggc_pkg::MAX_COLOR && taken[c])
                c++;
            vtx_colors[i] = ggc_pkg::COLOR_W'(c);
        end
        for (int i = 0; i < n; i++) begin
            res.vertex = ggc_pkg::VIDX_W'(i);
            res.color  = vtx_colors[i];
            res.last   = (i == n - 1);
            color_queue.insert(color_queue.size(), res);
        end
    endtask

    function automatic void check_field(input string label, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
            err_count++;
        end
    endfunction

    // sample both channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count = ggc_pkg::VCNT_RESET;
            color_queue.delete();
        end else begin
            if (cfg_wr_en)
                vertex_count = cfg_wr_data;

            // input transfer: a load updates a row, a start owes a coloring
            if (s_valid && s_ready) begin
                if (s_data.command == ggc_pkg::CMD_START)
                    predict_coloring();
                else
                    adj_rows[s_data.row_index] = s_data.row_flags;
            end

            // result transfer against the oldest owed result
            if (m_valid && m_ready) begin
                if (color_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual vertex %0d color %0d",
                             $time, m_data.vertex, m_data.color);
                    err_count++;
                end else begin
                    want = color_queue.pop_front();
                    check_field("vertex", 8'(want.vertex), 8'(m_data.vertex));
                    check_field("color", 8'(want.color), 8'(m_data.color));
                    check_field("last", 8'(want.last), 8'(m_data.last));
                end
            end
        end
        errors  <= err_count;
        pending <= color_queue.size();
    end

endmodule

// ===== dv/tb_greedy_graph_colorer_unit.sv =====
// testbench top of the greedy graph colorer: stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module tb_greedy_graph_colorer_unit;

    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 130;
    localparam int SETTLE_CYCLES = 16;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [ggc_pkg::VCNT_W-1:0] cfg_wr_data = '0;
    logic                       s_valid     = 1'b0;
    ggc_pkg::in_item_t          s_data      = '0;
    logic                       m_ready     = 1'b0;
    logic                       s_ready;
    logic                       m_valid;
    ggc_pkg::out_item_t         m_data;

    int errors;
    int pending;

    logic                             gaps_on      = 1'b0;
    logic                             stalls_on    = 1'b0;
    logic                             hold_req     = 1'b0;
    logic [ggc_pkg::MAX_VERTICES-1:0] rows_written = '0;
    logic [ggc_pkg::VCNT_W-1:0]       vcount_now   = ggc_pkg::VCNT_RESET;
    int                               item_count   = 0;
    int                               idle_cycles  = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    greedy_graph_colorer_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    ggc_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .errors      (errors),
        .pending     (pending)
    );

    // row contents of mixed density
    function automatic logic [ggc_pkg::ROW_W-1:0] random_flags();
        case ($urandom_range(0, 5))
            0:       return $urandom & $urandom & $urandom;
            1:       return $urandom | $urandom;
            2:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    // mostly small graphs, sometimes empty, full or above the clamp
    function automatic logic [ggc_pkg::VCNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ggc_pkg::VCNT_W'(1);
            2:       return ggc_pkg::VCNT_W'(ggc_pkg::MAX_VERTICES);
            3:       return ggc_pkg::VCNT_W'($urandom_range(ggc_pkg::MAX_VERTICES + 1, 63));
            default: return ggc_pkg::VCNT_W'($urandom_range(2, 12));
        endcase
    endfunction

    // offer one item and hold it until the transfer, then maybe leave a gap
    task automatic send_item(input ggc_pkg::in_item_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        item_count++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic load_row(input int idx, input logic [ggc_pkg::ROW_W-1:0] flags);
        ggc_pkg::in_item_t item;
        item.command   = ggc_pkg::CMD_LOAD;
        item.row_index = ggc_pkg::VIDX_W'(idx);
        item.row_flags = flags;
        send_item(item);
        rows_written[idx] = 1'b1;
    endtask

    // a start never reads a row that was not loaded since reset
    task automatic start_coloring();
        int                need;
        ggc_pkg::in_item_t item;
        need = (vcount_now > ggc_pkg::MAX_VERTICES)
             ? ggc_pkg::MAX_VERTICES : int'(vcount_now);
        if (need == 0)
            need = 1;
        for (int r = 0; r < need; r++) begin
            if (!rows_written[r])
                load_row(r, random_flags());
        end
        item.command   = ggc_pkg::CMD_START;
        item.row_index = ggc_pkg::VIDX_W'($urandom);
        item.row_flags = $urandom;
        send_item(item);
    endtask

    // stop offering and wait until every owed result has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_vertex_count(input logic [ggc_pkg::VCNT_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        vcount_now = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: random stall bursts, or one long hold on request
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any transfer, results nobody owes do not count
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready && pending != 0))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[greedy_graph_colorer_unit] ERROR");
        $finish;
    end

    // stimulus
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty graph gives no results, self-loop alone is no edge
        set_vertex_count('0);
        load_row(0, 32'h0000_0001);
        start_coloring();
        set_vertex_count(ggc_pkg::VCNT_W'(1));
        start_coloring();

        // edges flagged in one direction only, columns past the count
        load_row(1, 32'h0000_0001);
        load_row(2, 32'h0000_0000);
        load_row(3, 32'h8000_000F);
        set_vertex_count(ggc_pkg::VCNT_W'(4));
        start_coloring();
        load_row(0, 32'hFFFF_FFFF);
        load_row(2, 32'h0000_0002);
        start_coloring();

        // count above the clamp, all six bits set
        set_vertex_count(ggc_pkg::VCNT_W'(63));
        start_coloring();

        // complete graph reaches the top color on the top vertex
        for (int r = 0; r < ggc_pkg::MAX_VERTICES; r++)
            load_row(r, 32'hFFFF_FFFF);
        set_vertex_count(ggc_pkg::VCNT_W'(ggc_pkg::MAX_VERTICES));
        start_coloring();
        set_vertex_count(ggc_pkg::VCNT_W'(2));
        start_coloring();

        // long receiver hold while the sender keeps offering
        set_vertex_count(ggc_pkg::VCNT_W'(ggc_pkg::MAX_VERTICES));
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        hold_req  = 1'b1;
        start_coloring();
        for (int k = 0; k < 4; k++)
            load_row($urandom_range(0, ggc_pkg::MAX_VERTICES - 1), random_flags());
        start_coloring();

        // random phases: new count, then loads with starts in between
        while (item_count < RANDOM_ITEMS) begin
            if (item_count > RANDOM_ITEMS - 25) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            set_vertex_count(pick_count());
            repeat ($urandom_range(3, 9)) begin
                if ($urandom_range(0, 3) == 0)
                    start_coloring();
                else
                    load_row($urandom_range(0, ggc_pkg::MAX_VERTICES - 1), random_flags());
            end
            start_coloring();
        end

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        wait_drained();
        if (errors == 0)
            $display("[greedy_graph_colorer_unit] OK");
        else
            $display("[greedy_graph_colorer_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ggc_pkg.sv
rtl/core/ggc_ram.sv
rtl/core/ggc_datapath.sv
rtl/core/ggc_ctrl.sv
rtl/core/greedy_graph_colorer_unit.sv
dv/ggc_checker.sv
dv/tb_greedy_graph_colorer_unit.sv
